### rtl/core/bjm_pkg.sv
// Shared types and constants of the bounded jog motion profile core.
// No dependencies; every other file of the block imports this package.
package bjm_pkg;

	localparam int CFG_W   = 31;  // width of every configuration register
	localparam int TIME_W  = 16;  // tick time, unsigned Q0.16 seconds
	localparam int FRAC_W  = 16;  // fraction bits of Q16.16
	localparam int VAL_W   = 32;  // signed Q16.16 speed and position
	localparam int IDX_W   = 2;   // configuration register index
	localparam int NUM_W   = 48;  // divider dividend: magnitude << FRAC_W
	localparam int DEN_W   = 31;  // divider divisor: a rate
	localparam int OPA_W   = 34;  // signed multiplier operand
	localparam int OPB_W   = 17;  // unsigned multiplier operand
	localparam int PROD_W  = 52;  // signed product and movement sum
	localparam int MOVE_SH = 17;  // movement is held in units of 2^-33

	localparam logic [CFG_W-1:0] RATE_RESET  = 31'd65536;
	localparam logic [CFG_W-1:0] SPEED_RESET = 31'd65536;
	localparam logic [CFG_W-1:0] LEN_RESET   = 31'd65536;

	localparam logic [IDX_W-1:0] REG_ACCEL = 2'd0;
	localparam logic [IDX_W-1:0] REG_DECEL = 2'd1;
	localparam logic [IDX_W-1:0] REG_VMAX  = 2'd2;
	localparam logic [IDX_W-1:0] REG_HALF  = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_CHK,
		OP_DIV_START,
		OP_MUL_DV,
		OP_MUL_MOVL,
		OP_COMMIT_LONG,
		OP_MUL_MOVS,
		OP_COMMIT_SHORT,
		OP_MUL_COAST,
		OP_COAST_ADD,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t  op;
		logic accel;   // 1: acceleration phase, 0: braking phase
	} cmd_t;

	typedef struct packed {
		logic brk_need;
		logic acc_need;
		logic long_phase;  // phase outlasts the remaining time
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [CFG_W-1:0] accel;
		logic [CFG_W-1:0] decel;
		logic [CFG_W-1:0] vmax;
		logic [CFG_W-1:0] half;
	} cfg_t;

endpackage

### rtl/core/bjm_div.sv
// Restoring divider, one quotient bit per cycle, for phase durations.
// Depends on bjm_pkg; the caller guarantees the quotient fits TIME_W bits.
module bjm_div import bjm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [TIME_W-1:0] quo
);

	logic [VAL_W-1:0]  rem_q;
	logic [TIME_W-1:0] lo_q;
	logic [TIME_W-1:0] quo_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [VAL_W:0]    trial;
	logic [VAL_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, lo_q[TIME_W-1]};
	assign ge    = trial >= {2'b00, den};
	assign diff  = trial - {2'b00, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:TIME_W];
			lo_q  <= num[TIME_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			lo_q  <= {lo_q[TIME_W-2:0], 1'b0};
			quo_q <= {quo_q[TIME_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/bjm_dp.sv
// Datapath: speed/position state, shared multiplier, movement sum, clamp.
// Depends on bjm_pkg and bjm_div; driven by commands from bjm_ctrl.
module bjm_dp import bjm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  cfg_t              cfg,
	input  logic              neg_pressed,
	input  logic              pos_pressed,
	input  logic [TIME_W-1:0] tick_time,
	output sts_t              sts,
	output logic [VAL_W-1:0]  position,
	output logic [VAL_W-1:0]  speed,
	output logic              at_limit
);

	logic                     dpos_q, dneg_q;
	logic [TIME_W-1:0]        rem_q;
	logic signed [VAL_W-1:0]  v_q, pos_q;
	logic signed [PROD_W-1:0] m2_q, prod_q;
	logic [CFG_W-1:0]         dv_q;
	logic [VAL_W-1:0]         out_pos_q, out_spd_q;
	logic                     out_lim_q;

	logic                     dp_w, dn_w, vneg, vzero;
	logic [DEN_W-1:0]         acc_eff, dec_eff, den;
	logic signed [OPA_W-1:0]  v34, vmax34, dirv34, gap34, target34;
	logic [VAL_W-1:0]         vabs, mag;
	logic [NUM_W-1:0]         num;
	logic                     sd_neg;
	logic signed [OPA_W-1:0]  sd_prod, sd_q;
	logic signed [OPA_W-1:0]  mul_a;
	logic [OPB_W-1:0]         mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [TIME_W-1:0]        quo;
	logic                     div_done;
	logic signed [VAL_W+2:0]  move;
	logic signed [VAL_W+3:0]  pnew, lim36;

	assign dp_w  = dpos_q & ~dneg_q;
	assign dn_w  = dneg_q & ~dpos_q;
	assign vneg  = v_q[VAL_W-1];
	assign vzero = (v_q == '0);

	assign acc_eff = (cfg.accel == '0) ? DEN_W'(1) : cfg.accel;
	assign dec_eff = (cfg.decel == '0) ? DEN_W'(1) : cfg.decel;
	assign den     = cmd.accel ? acc_eff : dec_eff;

	assign v34    = OPA_W'(v_q);
	assign vmax34 = {3'b000, cfg.vmax};
	always_comb begin
		if (dp_w)      dirv34 = v34;
		else if (dn_w) dirv34 = -v34;
		else           dirv34 = '0;
	end
	assign gap34 = vmax34 - dirv34;
	assign vabs  = vneg ? (~v_q + VAL_W'(1)) : v_q;
	assign mag   = cmd.accel ? ((gap34 > 0) ? gap34[VAL_W-1:0] : '0) : vabs;
	assign num   = {mag, {FRAC_W{1'b0}}};

	always_comb begin
		if (!cmd.accel) target34 = '0;
		else if (dp_w)  target34 = vmax34;
		else if (dn_w)  target34 = -vmax34;
		else            target34 = '0;
	end

	// brake opposes the speed's sign, acceleration follows the direction
	assign sd_neg  = cmd.accel ? dn_w : ~vneg;
	assign sd_prod = sd_neg ? -OPA_W'(prod_q[46:16]) : OPA_W'(prod_q[46:16]);
	assign sd_q    = sd_neg ? -OPA_W'(dv_q) : OPA_W'(dv_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_CHK: begin
				mul_a = OPA_W'(den);
				mul_b = OPB_W'(rem_q) + OPB_W'(1);
			end
			OP_MUL_DV: begin
				mul_a = OPA_W'(den);
				mul_b = OPB_W'(rem_q);
			end
			OP_MUL_MOVL: begin
				mul_a = v34 + v34 + sd_prod;
				mul_b = OPB_W'(rem_q);
			end
			OP_MUL_MOVS: begin
				mul_a = v34 + target34;
				mul_b = OPB_W'(quo);
			end
			OP_MUL_COAST: begin
				mul_a = v34 + v34;
				mul_b = OPB_W'(rem_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a * $signed({1'b0, mul_b}));

	bjm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_START),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	// floor of the movement sum in Q16.16, then the new position
	assign move  = m2_q[PROD_W-1:MOVE_SH];
	assign pnew  = (VAL_W+4)'(pos_q) + (VAL_W+4)'(move);
	assign lim36 = {5'b00000, cfg.half};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			pos_q <= '0;
		end else begin
			case (cmd.op)
				OP_COMMIT_LONG:  v_q <= VAL_W'(v34 + sd_q);
				OP_COMMIT_SHORT: v_q <= VAL_W'(target34);
				OP_FINISH: begin
					if (pnew > lim36) begin
						pos_q <= VAL_W'(lim36);
						v_q   <= '0;
					end else if (pnew < -lim36) begin
						pos_q <= VAL_W'(-lim36);
						v_q   <= '0;
					end else begin
						pos_q <= VAL_W'(pnew);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_b != '0 || mul_a != '0 || cmd.op == OP_MUL_CHK || cmd.op == OP_MUL_DV ||
		    cmd.op == OP_MUL_MOVL || cmd.op == OP_MUL_MOVS || cmd.op == OP_MUL_COAST)
			prod_q <= mul_p;
		case (cmd.op)
			OP_LOAD: begin
				dpos_q <= pos_pressed;
				dneg_q <= neg_pressed;
				rem_q  <= tick_time;
				m2_q   <= '0;
			end
			OP_MUL_MOVL: dv_q <= prod_q[46:16];
			OP_COMMIT_LONG: begin
				m2_q  <= m2_q + prod_q;
				rem_q <= '0;
			end
			OP_COMMIT_SHORT: begin
				m2_q  <= m2_q + prod_q;
				rem_q <= rem_q - quo;
			end
			OP_COAST_ADD: m2_q <= m2_q + prod_q;
			OP_FINISH: begin
				if (pnew > lim36) begin
					out_pos_q <= VAL_W'(lim36);
					out_spd_q <= '0;
					out_lim_q <= 1'b1;
				end else if (pnew < -lim36) begin
					out_pos_q <= VAL_W'(-lim36);
					out_spd_q <= '0;
					out_lim_q <= 1'b1;
				end else begin
					out_pos_q <= VAL_W'(pnew);
					out_spd_q <= v_q;
					out_lim_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign sts.brk_need   = (rem_q != '0) && !vzero && !((dp_w && !vneg) || (dn_w && vneg));
	assign sts.acc_need   = (rem_q != '0) &&
	                        ((vzero && (dp_w || dn_w)) || (dp_w && !vneg && !vzero) ||
	                         (dn_w && vneg));
	assign sts.long_phase = num >= prod_q[NUM_W-1:0];
	assign sts.div_done   = div_done;

	assign position = out_pos_q;
	assign speed    = out_spd_q;
	assign at_limit = out_lim_q;

endmodule

### rtl/core/bjm_ctrl.sv
// Controller: sequences brake, accelerate and coast phases of one tick.
// Depends on bjm_pkg; issues commands to bjm_dp and reads its status.
module bjm_ctrl import bjm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_BTEST = 14'b00000000000010,
		ST_ATEST = 14'b00000000000100,
		ST_CHK   = 14'b00000000001000,
		ST_CMP   = 14'b00000000010000,
		ST_DIV   = 14'b00000000100000,
		ST_MOVS  = 14'b00000001000000,
		ST_ADDS  = 14'b00000010000000,
		ST_MOVL  = 14'b00000100000000,
		ST_ADDL  = 14'b00001000000000,
		ST_COAST = 14'b00010000000000,
		ST_CADD  = 14'b00100000000000,
		ST_FIN   = 14'b01000000000000,
		ST_SPARE = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   accel_q, accel_d;
	logic   out_valid_q;
	logic   finish;

	assign finish = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		accel_d   = accel_q;
		cmd.op    = OP_NONE;
		cmd.accel = accel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_BTEST;
				end
			end
			ST_BTEST: begin
				accel_d = 1'b0;
				state_d = sts.brk_need ? ST_CHK : ST_ATEST;
			end
			ST_ATEST: begin
				accel_d = 1'b1;
				state_d = sts.acc_need ? ST_CHK : ST_COAST;
			end
			ST_CHK: begin
				cmd.op  = OP_MUL_CHK;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.long_phase) begin
					cmd.op  = OP_MUL_DV;
					state_d = ST_MOVL;
				end else begin
					cmd.op  = OP_DIV_START;
					state_d = ST_DIV;
				end
			end
			ST_DIV:  if (sts.div_done) state_d = ST_MOVS;
			ST_MOVS: begin
				cmd.op  = OP_MUL_MOVS;
				state_d = ST_ADDS;
			end
			ST_ADDS: begin
				cmd.op  = OP_COMMIT_SHORT;
				state_d = accel_q ? ST_COAST : ST_ATEST;
			end
			ST_MOVL: begin
				cmd.op  = OP_MUL_MOVL;
				state_d = ST_ADDL;
			end
			ST_ADDL: begin
				cmd.op  = OP_COMMIT_LONG;
				state_d = accel_q ? ST_COAST : ST_ATEST;
			end
			ST_COAST: begin
				cmd.op  = OP_MUL_COAST;
				state_d = ST_CADD;
			end
			ST_CADD: begin
				cmd.op  = OP_COAST_ADD;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (finish) begin
					cmd.op  = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			accel_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			accel_q <= accel_d;
			if (finish)         out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide wait");
	a_accept_starts_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_BTEST)
		else $error("accepted word did not start the brake test");
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result word raised outside the finish step");
`endif

endmodule

### rtl/core/bounded_jog_motion_profile_core.sv
// Top level of the bounded jog motion profile core: configuration registers,
// controller and datapath. Depends on bjm_pkg, bjm_ctrl, bjm_dp (and bjm_div).
//
// channel  direction  handshake            word
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_ready    neg_pressed, pos_pressed, tick_time
// out      out        out_valid/out_ready  position, speed, at_limit
//
// A tick with no phase runs from accept to result through brake test, accelerate
// test, coast multiply, coast add and finish. Each brake or accelerate phase adds
// check, compare, movement multiply and commit when it outlasts the tick, else
// check, compare, shared divider wait, movement multiply and commit.
// Reset sets speed and position to zero and all registers to 1.0.
// A new word is accepted while the previous result waits; the finish step
// stalls until the output register is free. Configuration is always ready.
module bounded_jog_motion_profile_core import bjm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              neg_pressed,
	input  logic              pos_pressed,
	input  logic [TIME_W-1:0] tick_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VAL_W-1:0]  position,
	output logic [VAL_W-1:0]  speed,
	output logic              at_limit
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// register file: take a word whenever it is offered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel <= RATE_RESET;
			cfg_q.decel <= RATE_RESET;
			cfg_q.vmax  <= SPEED_RESET;
			cfg_q.half  <= LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACCEL: cfg_q.accel <= cfg_data;
				REG_DECEL: cfg_q.decel <= cfg_data;
				REG_VMAX:  cfg_q.vmax  <= cfg_data;
				REG_HALF:  cfg_q.half  <= cfg_data;
				default: ;
			endcase
		end
	end

	bjm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bjm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.neg_pressed (neg_pressed),
		.pos_pressed (pos_pressed),
		.tick_time   (tick_time),
		.sts         (sts),
		.position    (position),
		.speed       (speed),
		.at_limit    (at_limit)
	);

endmodule

### test/bounded_jog_motion_profile_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for bounded_jog_motion_profile_core: random jog ticks
// under varied register settings and back-pressure. Depends on bjm_pkg.
module bounded_jog_motion_profile_core_tb;
	import bjm_pkg::*;

	localparam int MAX_CYCLES = 1500000;
	localparam int DRAIN_CYCLES = 120;

	typedef struct packed {
		logic              neg;
		logic              pos;
		logic [TIME_W-1:0] dt;
	} tick_t;

	typedef struct packed {
		logic [VAL_W-1:0] position;
		logic [VAL_W-1:0] speed;
		logic             at_limit;
	} pose_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              neg_pressed;
	logic              pos_pressed;
	logic [TIME_W-1:0] tick_time;
	logic              out_valid;
	logic              out_ready;
	logic [VAL_W-1:0]  position;
	logic [VAL_W-1:0]  speed;
	logic              at_limit;

	bounded_jog_motion_profile_core u_dut (.*);

	// Predictor copy of the registers and motion state.
	longint unsigned mdl_accel, mdl_decel, mdl_vmax, mdl_half;
	longint mdl_speed, mdl_pos;

	tick_t tick_q[$];
	pose_t pose_q[$];
	int    mismatches;
	int    send_idle_pct;
	int    recv_stall_pct;
	bit    hold_off;
	int    hold_cycles;
	bit    in_acc;
	longint cycle_count = 0;

	function automatic longint floor_div_2p17(longint x);
		if (x >= 0)
			return x >>> 17;
		return -((-x + 131071) >>> 17);
	endfunction

	// Advance the motion state by one tick and return the expected word.
	function automatic pose_t advance_motion(tick_t t);
		longint dir, rem, v, acc, dec, vmax, lim, m2, mag, dur, dv, gap, p;
		pose_t r;
		dir  = longint'(t.pos) - longint'(t.neg);
		rem  = t.dt;
		v    = mdl_speed;
		acc  = mdl_accel ? longint'(mdl_accel) : 1;
		dec  = mdl_decel ? longint'(mdl_decel) : 1;
		vmax = mdl_vmax;
		lim  = mdl_half;
		m2   = 0;
		r.at_limit = 1'b0;
		// brake toward zero when released, when both are pressed or when reversing
		if (rem > 0 && v != 0 && dir * v <= 0) begin
			mag = v < 0 ? -v : v;
			dur = (mag <<< 16) / dec;
			if (dur > rem) begin
				dv = (dec * rem) >>> 16;
				if (v < 0) dv = -dv;
				m2 += (2 * v - dv) * rem;
				v -= dv;
				rem = 0;
			end else begin
				m2 += v * dur;
				v = 0;
				rem -= dur;
			end
		end
		// speed up toward the pushed direction
		if (rem > 0 && ((v == 0 && dir != 0) || dir * v > 0)) begin
			gap = vmax - dir * v;
			dur = gap > 0 ? (gap <<< 16) / acc : 0;
			if (dur > rem) begin
				dv = dir * ((acc * rem) >>> 16);
				m2 += (2 * v + dv) * rem;
				v += dv;
				rem = 0;
			end else begin
				m2 += (v + dir * vmax) * dur;
				v = dir * vmax;
				rem -= dur;
			end
		end
		m2 += 2 * v * rem;  // coast for what is left
		p = mdl_pos + floor_div_2p17(m2);
		if (p > lim) begin
			p = lim;
			v = 0;
			r.at_limit = 1'b1;
		end else if (p < -lim) begin
			p = -lim;
			v = 0;
			r.at_limit = 1'b1;
		end
		mdl_pos   = longint'(signed'(p[31:0]));
		mdl_speed = longint'(signed'(v[31:0]));
		r.position = p[31:0];
		r.speed    = v[31:0];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Watchdog: end the run on a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Drive queued ticks; hold valid and payload until accepted.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			neg_pressed <= 1'b0;
			pos_pressed <= 1'b0;
			tick_time   <= '0;
		end else if (in_valid && !in_acc) begin
			// hold
		end else if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			in_valid    <= 1'b1;
			neg_pressed <= tick_q[0].neg;
			pos_pressed <= tick_q[0].pos;
			tick_time   <= tick_q[0].dt;
			tick_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Predict at acceptance so register writes are ordered with the ticks.
	always @(posedge clk) begin
		tick_t t;
		in_acc <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			t.neg = neg_pressed;
			t.pos = pos_pressed;
			t.dt  = tick_time;
			pose_q.push_back(advance_motion(t));
		end
	end

	// Receiver stall pattern, plus a long hold-off when asked.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else begin
			out_ready   <= ($urandom_range(99) >= recv_stall_pct);
			hold_cycles <= 0;
		end
	end

	// Compare each accepted word with the oldest expectation.
	always @(posedge clk) begin
		pose_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (pose_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word pos=%h spd=%h lim=%b", position, speed,
						at_limit);
			end else begin
				exp_w = pose_q.pop_front();
				if (exp_w.position !== position || exp_w.speed !== speed ||
				    exp_w.at_limit !== at_limit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp pos=%h spd=%h lim=%b got pos=%h spd=%h lim=%b",
							exp_w.position, exp_w.speed, exp_w.at_limit,
							position, speed, at_limit);
				end
			end
		end
	end

	task automatic push_tick(bit n, bit p, int unsigned dt);
		tick_t t;
		t.neg = n;
		t.pos = p;
		t.dt  = dt[TIME_W-1:0];
		tick_q.push_back(t);
	endtask

	// Wait for drain, then let the block settle before a register write.
	task automatic wait_idle();
		while (tick_q.size() > 0 || in_valid || pose_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ACCEL: mdl_accel = val;
			REG_DECEL: mdl_decel = val;
			REG_VMAX:  mdl_vmax  = val;
			default:   mdl_half  = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_profile(int unsigned a, int unsigned d, int unsigned vm,
		int unsigned h);
		write_reg(REG_ACCEL, a[CFG_W-1:0]);
		write_reg(REG_DECEL, d[CFG_W-1:0]);
		write_reg(REG_VMAX, vm[CFG_W-1:0]);
		write_reg(REG_HALF, h[CFG_W-1:0]);
	endtask

	function automatic int unsigned rand_reg();
		case ($urandom_range(4))
			0: return 1;
			1: return 32'h7fffffff;
			2: return $urandom_range(1 << 20, 1);
			default: return $urandom & 32'h7fffffff;
		endcase
	endfunction

	// Random jog bursts: mostly held buttons, some releases and noise.
	task automatic random_burst(int n);
		int unsigned dt;
		int dirsel;
		repeat (n) begin
			dirsel = $urandom_range(9);
			case ($urandom_range(3))
				0: dt = $urandom_range(65535);
				1: dt = $urandom_range(4096);
				2: dt = $urandom_range(65535, 60000);
				default: dt = $urandom_range(300);
			endcase
			if (dirsel < 4)      push_tick(1'b0, 1'b1, dt);
			else if (dirsel < 8) push_tick(1'b1, 1'b0, dt);
			else                 push_tick(dirsel[0], dirsel[0], dt);
		end
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		mdl_accel = RATE_RESET;
		mdl_decel = RATE_RESET;
		mdl_vmax  = SPEED_RESET;
		mdl_half  = LEN_RESET;
		mdl_speed = 0;
		mdl_pos   = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed: reset profile, both buttons, zero time, full ticks to the bound.
		push_tick(1'b0, 1'b0, 0);
		push_tick(1'b0, 1'b1, 0);
		push_tick(1'b0, 1'b1, 16'hffff);
		push_tick(1'b0, 1'b1, 16'hffff);
		push_tick(1'b1, 1'b1, 16'h8000);
		push_tick(1'b0, 1'b1, 16'hffff);
		push_tick(1'b0, 1'b1, 16'hffff);
		push_tick(1'b1, 1'b0, 16'h4000);
		push_tick(1'b0, 1'b1, 16'h4000);
		push_tick(1'b0, 1'b0, 16'h0001);
		push_tick(1'b1, 1'b0, 16'hffff);
		push_tick(1'b1, 1'b0, 16'hffff);
		push_tick(1'b1, 1'b0, 16'hffff);
		wait_idle();

		// Fast profile, then shrink max speed and the line while moving.
		set_profile(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_tick(1'b0, 1'b1, 16'hffff);
		push_tick(1'b1, 1'b0, 16'h0100);
		push_tick(1'b0, 1'b1, 16'h0100);
		wait_idle();
		set_profile(0, 0, 32'h10000, 32'h100);
		push_tick(1'b0, 1'b1, 16'h0010);
		push_tick(1'b0, 1'b1, 16'hffff);
		push_tick(1'b0, 1'b0, 16'hffff);
		wait_idle();
		set_profile(32'h20000, 32'h8000, 0, 0);
		push_tick(1'b1, 1'b0, 16'hffff);
		push_tick(1'b0, 1'b1, 16'h1234);
		wait_idle();

		// Random phases with changing register settings and idling mixes.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			if (ph == 0)
				set_profile(32'h40000, 32'h80000, 32'h30000, 32'h50000);
			else
				set_profile(rand_reg(), rand_reg(), rand_reg(), rand_reg());
			random_burst(200);
			if (ph == 2) begin
				// Long receiver hold-off while ticks keep coming.
				hold_off = 1'b1;
				while (hold_cycles < 400) @(posedge clk);
				hold_off = 1'b0;
			end
			// Sender pauses until all expected words are back.
			while (tick_q.size() > 0 || in_valid) @(posedge clk);
			while (pose_q.size() > 0) @(posedge clk);
			random_burst(50);
			wait_idle();
		end

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
